>>> src/idps_pkg.sv
`timescale 1ns / 1ps
package idps_pkg;

  localparam int N_FIELDS = 6;
  localparam int FIELD_W  = 32;
  localparam int DIFF_W   = 33;
  localparam int SQ_W     = 68;
  localparam int ROOT_W   = 34;
  localparam int SQREM_W  = 37;
  localparam int WGT_W    = 53;
  localparam int DIV_W    = 64;
  localparam int QUO_W    = 42;
  localparam int LEN_W    = 4;
  localparam int PADDR_W  = 3;

  localparam logic [WGT_W-1:0] ZERO_WEIGHT   = WGT_W'(64'd1000000 << 32);
  localparam logic [DIV_W-1:0] INV_DIVIDEND  = DIV_W'(64'd1 << 48);
  localparam logic [LEN_W-1:0] WLEN_RESET    = LEN_W'(8);
  localparam logic             IDX_WINDOW_LENGTH = 1'b0;

  typedef logic [N_FIELDS-1:0][FIELD_W-1:0] sample_t;

  typedef struct packed {
    logic             go;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b00000000001,
    ST_READ = 11'b00000000010,
    ST_LOAD = 11'b00000000100,
    ST_SQ   = 11'b00000001000,
    ST_CHK  = 11'b00000010000,
    ST_SQRT = 11'b00000100000,
    ST_INV  = 11'b00001000000,
    ST_WMUL = 11'b00010000000,
    ST_NEXT = 11'b00100000000,
    ST_FDIV = 11'b01000000000,
    ST_DONE = 11'b10000000000
  } state_e;

endpackage

>>> src/idps_in_if.sv
`timescale 1ns / 1ps
interface idps_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rot_x;
  logic signed [31:0] rot_y;
  logic signed [31:0] rot_z;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (output valid, rot_x, rot_y, rot_z, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, pos_x, pos_y, pos_z, output ready);
endinterface

>>> src/idps_out_if.sv
`timescale 1ns / 1ps
interface idps_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] avg_rot_x;
  logic signed [31:0] avg_rot_y;
  logic signed [31:0] avg_rot_z;
  logic signed [31:0] avg_pos_x;
  logic signed [31:0] avg_pos_y;
  logic signed [31:0] avg_pos_z;

  modport source (output valid, avg_rot_x, avg_rot_y, avg_rot_z, avg_pos_x, avg_pos_y,
                  avg_pos_z, input ready);
  modport sink (input valid, avg_rot_x, avg_rot_y, avg_rot_z, avg_pos_x, avg_pos_y,
                avg_pos_z, output ready);
endinterface

>>> src/idps_div.sv
`timescale 1ns / 1ps
module idps_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  idps_pkg::div_req_t req_i,
  output idps_pkg::div_rsp_t rsp_o
);
  import idps_pkg::*;

  logic [DIV_W-1:0] rem_q, quo_q, dvs_q;
  logic [5:0]       cnt_q;
  logic             busy_q, done_q;
  logic [DIV_W:0]   rs;
  logic             ge;

  // restoring division, one quotient bit a cycle
  assign rs = {rem_q, quo_q[DIV_W-1]};
  assign ge = rs >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.go) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        quo_q  <= req_i.dividend;
        dvs_q  <= req_i.divisor;
      end else if (busy_q) begin
        rem_q <= ge ? DIV_W'(rs - {1'b0, dvs_q}) : DIV_W'(rs);
        quo_q <= {quo_q[DIV_W-2:0], ge};
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;
endmodule

>>> src/inverse_distance_pose_smoother.sv
`timescale 1ns / 1ps
// per window entry: square, root, inverse and weighting; an entry equal to the newest sample (the
// newest entry always is) skips root and inverse; then six final divisions and the output load
// a sample is taken only in idle; the 64-step divider and 34-step root dominate
// the result waits in an output register while the next sample is taken
// reset clears the sample window (row valid bits), the slot pointer and sets L to 8
module inverse_distance_pose_smoother #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [idps_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  idps_in_if.sink                       pose_i,
  idps_out_if.source                    avg_o
);
  import idps_pkg::*;

  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);

  state_e state_q;

  logic [LEN_W-1:0]  wlen_q, len_q, k_q;
  logic [SLOT_W-1:0] oldest_q, slot_q;
  logic [WINDOW_DEPTH-1:0] vld_q;
  sample_t mem_q [WINDOW_DEPTH];
  sample_t rd_q;
  logic    rd_vld_q;

  sample_t newest_q;
  logic signed [DIFF_W-1:0] d_q [N_FIELDS];
  logic [DIV_W-1:0] num_q [N_FIELDS];
  logic [DIV_W-1:0] den_q;
  logic [31:0]      res_q [N_FIELDS];
  logic [31:0]      out_q [N_FIELDS];
  logic             out_valid_q;

  logic [2:0] j_q;
  logic [1:0] ph_q;
  logic [5:0] scnt_q;
  logic [SQ_W-1:0]    sq_q;
  logic [SQREM_W-1:0] sqrem_q;
  logic [ROOT_W-1:0]  root_q;
  logic [WGT_W-1:0]   w_q;

  logic signed [DIFF_W-1:0]   ma, mb;
  logic signed [2*DIFF_W-1:0] prod_q;

  div_req_t div_req_q;
  div_rsp_t div_rsp;

  logic in_xfer, cfg_wr;
  sample_t in_row;
  logic [SQREM_W-1:0] rm, trial;
  logic ge;
  logic [LEN_W-1:0] len_eff;
  logic signed [QUO_W-1:0] qm, fl, res;
  logic rmz;
  logic [31:0] sat;

  idps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  // configuration
  assign pready = 1'b1;
  assign prdata = {28'd0, wlen_q};
  assign cfg_wr = psel && penable && pwrite;

  assign pose_i.ready = (state_q == ST_IDLE);
  assign in_xfer      = pose_i.valid && pose_i.ready;
  assign in_row = {pose_i.pos_z, pose_i.pos_y, pose_i.pos_x,
                   pose_i.rot_z, pose_i.rot_y, pose_i.rot_x};

  always_comb begin
    if (wlen_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (int'(wlen_q) > WINDOW_DEPTH) begin
      len_eff = LEN_W'(WINDOW_DEPTH);
    end else begin
      len_eff = wlen_q;
    end
  end

  // shared multiplier operands
  always_comb begin
    ma = d_q[j_q];
    mb = d_q[j_q];
    if (state_q == ST_WMUL) begin
      ma = ph_q[1] ? $signed({12'd0, w_q[WGT_W-1:32]}) : $signed({1'b0, w_q[31:0]});
    end
  end

  // square-root step
  assign rm    = {sqrem_q[SQREM_W-3:0], sq_q[SQ_W-1:SQ_W-2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign ge    = rm >= trial;

  // final division result, truncated toward zero and saturated
  always_comb begin
    qm  = $signed(div_rsp.quot[QUO_W-1:0]);
    rmz = |div_rsp.rem;
    fl  = num_q[j_q][DIV_W-1] ? (-qm - QUO_W'(rmz)) : qm;
    res = $signed({{(QUO_W-32){newest_q[j_q][31]}}, newest_q[j_q]}) + fl;
    if (rmz && res < 0) begin
      res = res + QUO_W'(1);
    end
    if (res > $signed(QUO_W'(32'h7fffffff))) begin
      sat = 32'h7fffffff;
    end else if (res < -$signed(QUO_W'(33'h080000000))) begin
      sat = 32'h80000000;
    end else begin
      sat = res[31:0];
    end
  end

  // sample memory, valid bit per row stands in for the reset clear
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mem_q[oldest_q] <= in_row;
    end
    rd_q <= mem_q[slot_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        vld_q[oldest_q] <= 1'b1;
      end
      rd_vld_q <= vld_q[slot_q];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wlen_q      <= WLEN_RESET;
      len_q       <= '0;
      k_q         <= '0;
      oldest_q    <= '0;
      slot_q      <= '0;
      newest_q    <= '0;
      den_q       <= '0;
      j_q         <= '0;
      ph_q        <= '0;
      scnt_q      <= '0;
      sq_q        <= '0;
      sqrem_q     <= '0;
      root_q      <= '0;
      w_q         <= '0;
      div_req_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < N_FIELDS; i++) begin
        d_q[i]   <= '0;
        num_q[i] <= '0;
        res_q[i] <= '0;
        out_q[i] <= '0;
      end
    end else begin
      div_req_q.go <= 1'b0;
      if (cfg_wr && paddr[2] == IDX_WINDOW_LENGTH) begin
        wlen_q <= pwdata[LEN_W-1:0];
      end
      if (avg_o.valid && avg_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            newest_q <= in_row;
            slot_q   <= oldest_q;
            oldest_q <= (oldest_q == SLOT_LAST) ? '0 : oldest_q + SLOT_W'(1);
            len_q    <= len_eff;
            k_q      <= '0;
            den_q    <= '0;
            for (int i = 0; i < N_FIELDS; i++) begin
              num_q[i] <= '0;
            end
            state_q  <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          for (int i = 0; i < N_FIELDS; i++) begin
            d_q[i] <= (rd_vld_q ? $signed({rd_q[i][31], rd_q[i]}) : '0)
                      - $signed({newest_q[i][31], newest_q[i]});
          end
          sq_q    <= '0;
          j_q     <= '0;
          ph_q    <= '0;
          state_q <= ST_SQ;
        end
        ST_SQ: begin
          ph_q <= {1'b0, ~ph_q[0]};
          if (ph_q[0]) begin
            sq_q <= sq_q + {{(SQ_W-64){1'b0}}, prod_q[63:0]};
            if (j_q == 3'(N_FIELDS - 1)) begin
              state_q <= ST_CHK;
            end else begin
              j_q <= j_q + 3'd1;
            end
          end
        end
        ST_CHK: begin
          j_q  <= '0;
          ph_q <= '0;
          if (sq_q == '0) begin
            w_q     <= ZERO_WEIGHT;
            state_q <= ST_WMUL;
          end else begin
            sqrem_q <= '0;
            root_q  <= '0;
            scnt_q  <= '0;
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          sqrem_q <= ge ? rm - trial : rm;
          root_q  <= {root_q[ROOT_W-2:0], ge};
          sq_q    <= {sq_q[SQ_W-3:0], 2'b00};
          scnt_q  <= scnt_q + 6'd1;
          if (scnt_q == 6'(ROOT_W - 1)) begin
            div_req_q.go       <= 1'b1;
            div_req_q.dividend <= INV_DIVIDEND;
            div_req_q.divisor  <= {{(DIV_W-ROOT_W){1'b0}}, root_q[ROOT_W-2:0], ge};
            state_q            <= ST_INV;
          end
        end
        ST_INV: begin
          if (div_rsp.done) begin
            w_q     <= div_rsp.quot[WGT_W-1:0];
            state_q <= ST_WMUL;
          end
        end
        ST_WMUL: begin
          ph_q <= ph_q + 2'd1;
          // low half of the weight, then the high half shifted up by 32
          if (ph_q == 2'd1) begin
            num_q[j_q] <= num_q[j_q] + prod_q[DIV_W-1:0];
          end else if (ph_q == 2'd3) begin
            num_q[j_q] <= num_q[j_q] + {prod_q[31:0], 32'd0};
            if (j_q == 3'(N_FIELDS - 1)) begin
              state_q <= ST_NEXT;
            end else begin
              j_q <= j_q + 3'd1;
            end
          end
        end
        ST_NEXT: begin
          den_q <= den_q + {{(DIV_W-WGT_W){1'b0}}, w_q};
          if (k_q == len_q - LEN_W'(1)) begin
            j_q     <= '0;
            state_q <= ST_FDIV;
            div_req_q.go       <= 1'b1;
            div_req_q.dividend <= num_q[0][DIV_W-1] ? -num_q[0] : num_q[0];
            div_req_q.divisor  <= den_q + {{(DIV_W-WGT_W){1'b0}}, w_q};
          end else begin
            k_q     <= k_q + LEN_W'(1);
            slot_q  <= (slot_q == '0) ? SLOT_LAST : slot_q - SLOT_W'(1);
            state_q <= ST_READ;
          end
        end
        ST_FDIV: begin
          if (div_rsp.done) begin
            res_q[j_q] <= sat;
            if (j_q == 3'(N_FIELDS - 1)) begin
              state_q <= ST_DONE;
            end else begin
              j_q                <= j_q + 3'd1;
              div_req_q.go       <= 1'b1;
              div_req_q.dividend <= num_q[j_q + 3'd1][DIV_W-1] ? -num_q[j_q + 3'd1]
                                                                : num_q[j_q + 3'd1];
            end
          end
        end
        ST_DONE: begin
          if (!out_valid_q || avg_o.ready) begin
            for (int i = 0; i < N_FIELDS; i++) begin
              out_q[i] <= res_q[i];
            end
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign avg_o.valid     = out_valid_q;
  assign avg_o.avg_rot_x = out_q[0];
  assign avg_o.avg_rot_y = out_q[1];
  assign avg_o.avg_rot_z = out_q[2];
  assign avg_o.avg_pos_x = out_q[3];
  assign avg_o.avg_pos_y = out_q[4];
  assign avg_o.avg_pos_z = out_q[5];
endmodule
